// File: design/keypad_repeat_hold_encoder_defines.svh
// Assertion macros for the keypad repeat/hold encoder checker.
// No dependencies; included by the checker file only.
`ifndef KEYPAD_REPEAT_HOLD_ENCODER_DEFINES_SVH
`define KEYPAD_REPEAT_HOLD_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KRH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KRH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/krh_pkg.sv
// Shared types, widths and the key code table of the keypad repeat/hold encoder.
// No dependencies.
package krh_pkg;

	localparam int MASK_W  = 16;
	localparam int IDX_W   = 4;
	localparam int CODE_W  = 7;
	localparam int COUNT_W = 3;

	localparam logic [COUNT_W-1:0] HOLD_RESET = 3'd3;

	// ASCII codes, key index row*4+col
	localparam logic [CODE_W-1:0] KEY_TABLE [MASK_W] = '{
		7'h2E, 7'h30, 7'h0A, 7'h33,
		7'h32, 7'h31, 7'h36, 7'h35,
		7'h34, 7'h2B, 7'h39, 7'h38,
		7'h37, 7'h2D, 7'h2A, 7'h2F
	};

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_CONF  = 3'b010,
		PH_HOLD  = 3'b100
	} phase_t;

	// snapshot handed from the phase logic to the serializer
	typedef struct packed {
		logic              emit;
		logic [MASK_W-1:0] mask;
	} load_t;

endpackage

// File: design/krh_ctrl.sv
// Phase tracking: previous snapshot, idle/confirm/hold phase, scan count, hold register.
// Depends on krh_pkg.
module krh_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [krh_pkg::MASK_W-1:0]  key_mask,
	input  logic                        cfg_wr_en,
	input  logic [krh_pkg::COUNT_W-1:0] cfg_wr_data,
	output krh_pkg::load_t              load
);
	import krh_pkg::*;

	logic [MASK_W-1:0]  prev_mask_q;
	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] hold_q;
	logic [COUNT_W-1:0] limit;
	logic [COUNT_W-1:0] count_inc;
	logic               hit;
	logic               repeat_hit;
	logic               emit;

	assign repeat_hit = |(key_mask & prev_mask_q);
	assign limit      = (hold_q == '0) ? COUNT_W'(1) : hold_q;
	assign count_inc  = count_q + COUNT_W'(1);
	assign hit        = (count_inc >= limit);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		emit    = 1'b0;
		if (!repeat_hit) begin
			emit    = (phase_q != PH_CONF) && (phase_q != PH_HOLD);
			phase_d = PH_IDLE;
			count_d = '0;
		end else begin
			case (phase_q)
				PH_CONF: begin
					count_d = hit ? '0 : count_inc;
					if (hit)
						phase_d = PH_HOLD;
				end
				PH_HOLD: begin
					count_d = hit ? '0 : count_inc;
					emit    = hit;
				end
				default: begin
					phase_d = PH_CONF;
					count_d = '0;
				end
			endcase
		end
	end

	assign load.emit = accept && emit && (|key_mask);
	assign load.mask = key_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mask_q <= '0;
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			hold_q      <= HOLD_RESET;
		end else begin
			if (cfg_wr_en)
				hold_q <= cfg_wr_data;
			if (accept) begin
				prev_mask_q <= key_mask;
				phase_q     <= phase_d;
				count_q     <= count_d;
			end
		end
	end

endmodule

// File: design/krh_serializer.sv
// Bit-serial key scan: shifts the snapshot out MSB first into an output register, one key
// position per cycle unless a pressed key waits on a stalled output. Depends on krh_pkg.
module krh_serializer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  krh_pkg::load_t             load,
	output logic                       busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [krh_pkg::CODE_W-1:0] key_code,
	output logic [krh_pkg::IDX_W-1:0]  key_index,
	output logic                       last_key
);
	import krh_pkg::*;

	logic [MASK_W-1:0] shift_q;
	logic [IDX_W-1:0]  idx_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;
	logic              slot_free;
	logic              advance;
	logic              put;
	logic              rest_empty;

	assign slot_free  = !out_valid_q || out_ready;
	assign advance    = busy_q && (!shift_q[MASK_W-1] || slot_free);
	assign put        = advance && shift_q[MASK_W-1];
	assign rest_empty = ~|shift_q[MASK_W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load.emit)
				busy_q <= 1'b1;
			else if (advance && (rest_empty || idx_q == '0))
				busy_q <= 1'b0;
			if (put)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (load.emit) begin
			shift_q <= load.mask;
			idx_q   <= IDX_W'(MASK_W - 1);
		end else if (advance) begin
			shift_q <= {shift_q[MASK_W-2:0], 1'b0};
			idx_q   <= idx_q - IDX_W'(1);
		end
		if (put) begin
			code_q  <= KEY_TABLE[idx_q];
			index_q <= idx_q;
			last_q  <= rest_empty;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign key_code  = code_q;
	assign key_index = index_q;
	assign last_key  = last_q;

endmodule

// File: design/keypad_repeat_hold_encoder.sv
// Flow: an accepted snapshot that emits is loaded into the serializer, and each pressed key's
// word is registered in the output register as the scan reaches it. The scan walks key positions
// 15..0, one per cycle unless an output stall holds it, stopping after the lowest pressed key;
// in_ready stays low until the scan ends, and a snapshot that emits nothing leaves it high.
// Reset (arst_n, async): idle phase, count and previous snapshot zero, hold count 3.
// Top level of the keypad repeat/hold encoder; instantiates krh_ctrl and krh_serializer.
module keypad_repeat_hold_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [krh_pkg::MASK_W-1:0]  key_mask,
	input  logic                        cfg_wr_en,
	input  logic [krh_pkg::COUNT_W-1:0] cfg_wr_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [krh_pkg::CODE_W-1:0]  key_code,
	output logic [krh_pkg::IDX_W-1:0]   key_index,
	output logic                        last_key
);
	import krh_pkg::*;

	load_t load;
	logic  busy;
	logic  accept;

	assign in_ready = !busy;
	assign accept   = in_valid && !busy;

	krh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.key_mask    (key_mask),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.load        (load)
	);

	krh_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_code  (key_code),
		.key_index (key_index),
		.last_key  (last_key)
	);

endmodule

// File: design/krh_checker.sv
// Port-level checks for the keypad repeat/hold encoder, bound to the top level.
// Depends on krh_pkg and keypad_repeat_hold_encoder_defines.svh.
`include "keypad_repeat_hold_encoder_defines.svh"

module krh_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [krh_pkg::CODE_W-1:0] key_code,
	input logic [krh_pkg::IDX_W-1:0]  key_index,
	input logic                       last_key
);
	import krh_pkg::*;

	// a stalled word holds
	`KRH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_code) && $stable(key_index) && $stable(last_key), "output word changed while stalled")

	// while a non-final key waits, the snapshot is still being scanned
	`KRH_ASSERT_NOW(a_busy_mid, out_valid && !last_key, !in_ready, "input opened before last key")

	// handing off a non-final key leaves the scan running or the next word loaded
	`KRH_ASSERT_NEXT(a_busy_after, out_valid && out_ready && !last_key, out_valid || !in_ready, "scan ended without last key")

endmodule

bind keypad_repeat_hold_encoder krh_port_checker u_krh_port_checker (.*);

// File: bench/krh_checker.sv
// Scoreboard for the keypad repeat/hold encoder: tracks the hold state from accepted scans,
// queues the key words each scan should produce and compares them with the output channel.
// Depends on krh_pkg.
module krh_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [krh_pkg::MASK_W-1:0]  key_mask,
	input  logic                        cfg_wr_en,
	input  logic [krh_pkg::COUNT_W-1:0] cfg_wr_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [krh_pkg::CODE_W-1:0]  key_code,
	input  logic [krh_pkg::IDX_W-1:0]   key_index,
	input  logic                        last_key,
	output int                          fail_count,
	output int                          pending,
	output int                          keys_seen
);
	import krh_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} key_word_t;

	// ASCII per key position, row*4+col
	localparam logic [CODE_W-1:0] ASCII_OF [MASK_W] = '{
		7'h2E, 7'h30, 7'h0A, 7'h33,
		7'h32, 7'h31, 7'h36, 7'h35,
		7'h34, 7'h2B, 7'h39, 7'h38,
		7'h37, 7'h2D, 7'h2A, 7'h2F
	};

	key_word_t          want_q[$];
	logic [COUNT_W-1:0] hold_cfg;
	logic [MASK_W-1:0]  prev_mask;
	phase_t             phase;
	logic [COUNT_W-1:0] scan_cnt;

	initial begin
		fail_count = 0;
		keys_seen  = 0;
		pending    = 0;
	end

	// a hold count of zero acts as one
	function automatic bit hold_count_reached();
		scan_cnt = scan_cnt + 1'b1;
		if (scan_cnt >= ((hold_cfg == '0) ? 3'd1 : hold_cfg)) begin
			scan_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// pressed keys go out from index 15 down, last flag on the lowest one
	task automatic queue_keys(input logic [MASK_W-1:0] m);
		int i;
		int lowest;
		key_word_t w;
		lowest = -1;
		for (i = 0; i < MASK_W; i++) begin
			if (m[i] && lowest < 0)
				lowest = i;
		end
		for (i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				w.code = ASCII_OF[i];
				w.idx  = i[IDX_W-1:0];
				w.last = (i == lowest);
				want_q.push_back(w);
			end
		end
	endtask

	task automatic predict_scan(input logic [MASK_W-1:0] m);
		logic rep;
		rep = |(m & prev_mask);
		prev_mask = m;
		if (!rep) begin
			if (phase != PH_CONF && phase != PH_HOLD)
				queue_keys(m);
			phase = PH_IDLE;
			scan_cnt = '0;
		end else if (phase == PH_CONF) begin
			if (hold_count_reached())
				phase = PH_HOLD;
		end else if (phase == PH_HOLD) begin
			if (hold_count_reached())
				queue_keys(m);
		end else begin
			phase = PH_CONF;
			scan_cnt = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_word_t w;
		if (!arst_n) begin
			hold_cfg  = HOLD_RESET;
			prev_mask = '0;
			phase     = PH_IDLE;
			scan_cnt  = '0;
			want_q.delete();
		end else begin
			if (cfg_wr_en)
				hold_cfg = cfg_wr_data;
			if (in_valid && in_ready)
				predict_scan(key_mask);
			if (out_valid && out_ready) begin
				if (want_q.size() == 0) begin
					fail_count++;
					$display("%0t: expected no key word, got code %h index %0d last %b",
						$time, key_code, key_index, last_key);
				end else begin
					w = want_q.pop_front();
					keys_seen++;
					check_field("key_code", 16'(w.code), 16'(key_code));
					check_field("key_index", 16'(w.idx), 16'(key_index));
					check_field("last_key", 16'(w.last), 16'(last_key));
				end
			end
		end
		pending = want_q.size();
	end

endmodule

// File: bench/tb_keypad_repeat_hold_encoder.sv
// Bench top for the keypad repeat/hold encoder: clock, reset, scan and hold-count stimulus,
// output back-pressure and the verdict. Depends on krh_pkg, keypad_repeat_hold_encoder, krh_checker.
module tb_keypad_repeat_hold_encoder;
	import krh_pkg::*;

	localparam int CYCLE_LIMIT    = 800000;
	localparam int SQUEEZE_CYCLES = 250;
	localparam int SCANS_PER_HOLD = 40;
	localparam logic [COUNT_W-1:0] HOLD_PLAN [8] = '{
		3'd7, 3'd1, 3'd0, 3'd5, 3'd2, 3'd6, 3'd4, 3'd3
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [MASK_W-1:0]  key_mask;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	logic               out_valid;
	logic               out_ready;
	logic [CODE_W-1:0]  key_code;
	logic [IDX_W-1:0]   key_index;
	logic               last_key;

	int fail_count;
	int pending;
	int keys_seen;
	int scans_sent = 0;
	int cycle_cnt = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;

	keypad_repeat_hold_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_mask    (key_mask),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_code    (key_code),
		.key_index   (key_index),
		.last_key    (last_key)
	);

	krh_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_mask    (key_mask),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_code    (key_code),
		.key_index   (key_index),
		.last_key    (last_key),
		.fail_count  (fail_count),
		.pending     (pending),
		.keys_seen   (keys_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d key words outstanding", cycle_cnt, pending);
			$display("tb_keypad_repeat_hold_encoder: FAIL");
			$finish;
		end
	end

	// returns at the rising edge where the scan word is taken
	task automatic send_scan(input logic [MASK_W-1:0] m);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			key_mask <= 16'($urandom);
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		key_mask <= m;
		do @(posedge clk); while (!in_ready);
		scans_sent++;
	endtask

	// only written once the block has gone quiet
	task automatic set_hold(input logic [COUNT_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [MASK_W-1:0] pick_keys();
		logic [MASK_W-1:0] m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: m = 16'd1 << $urandom_range(0, 15);
			5, 6, 7: m = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
			default: m = 16'($urandom);
		endcase
		if (m == '0)
			m = 16'h8000;
		return m;
	endfunction

	// mostly press, hold for a random number of scans, release; some noise scans
	task automatic random_episode(input logic [COUNT_W-1:0] hold);
		int len;
		int i;
		int eff;
		logic [MASK_W-1:0] base;
		logic [MASK_W-1:0] m;
		eff = (hold == '0) ? 1 : int'(hold);
		case ($urandom_range(0, 9))
			0, 1: send_scan(16'($urandom));
			2: send_scan('0);
			default: begin
				base = pick_keys();
				len = $urandom_range(1, 3 * eff + 4);
				send_scan(base);
				m = base;
				for (i = 0; i < len; i++) begin
					m = base;
					if ($urandom_range(0, 3) == 0)
						m = m | 16'($urandom);
					send_scan(m);
				end
				if ($urandom_range(0, 1) == 0)
					send_scan('0);
				else
					send_scan(pick_keys() & ~m);
			end
		endcase
	endtask

	initial begin : rx_side
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int p;
		int k;
		int target;
		in_valid    = 1'b0;
		key_mask    = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		arst_n      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset hold count of three
		send_scan(16'h0000);
		send_scan(16'hFFFF);
		send_scan(16'h0001);
		send_scan(16'h0001);
		send_scan(16'h0001);
		send_scan(16'h0001);
		send_scan(16'h0003);
		send_scan(16'h0003);
		send_scan(16'h8001);
		send_scan(16'h0100);
		send_scan(16'h8000);
		send_scan(16'h5555);
		send_scan(16'hAAAA);
		send_scan(16'hAAAA);
		send_scan(16'h0000);

		// zero count must act as one
		set_hold(3'd0);
		send_scan(16'h1234);
		send_scan(16'h1234);
		send_scan(16'h0004);
		send_scan(16'h0004);
		send_scan(16'h0004);
		send_scan(16'h0000);

		for (p = 0; p < 8; p++) begin
			set_hold(HOLD_PLAN[p]);
			if (p == 7) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			if (p == 1) begin
				// receiver holds off while full scans keep coming
				gaps_on = 1'b0;
				squeeze_req = 1'b1;
				for (k = 0; k < 10; k++)
					send_scan(k[0] ? 16'hF0F0 : 16'h0F0F);
				gaps_on = 1'b1;
			end
			target = scans_sent + SCANS_PER_HOLD;
			while (scans_sent < target)
				random_episode(HOLD_PLAN[p]);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(negedge clk);

		$display("Covered %0d scans over hold counts 0 to 7, %0d key words compared,",
			scans_sent, keys_seen);
		$display("with random gaps and stalls and one %0d-cycle output hold-off.",
			SQUEEZE_CYCLES);
		if (fail_count == 0)
			$display("tb_keypad_repeat_hold_encoder: PASS");
		else
			$display("tb_keypad_repeat_hold_encoder: FAIL");
		$finish;
	end

endmodule
